// File: src/pwl_pkg.sv
// ----------------------------------------------------------------------------
// pwl_pkg - shared types and constants for the piecewise-linear table unit
// Beat payloads, status codes, function codes and derived arithmetic widths.
// ----------------------------------------------------------------------------
package pwl_pkg;

	localparam int COORD_WIDTH    = 16;
	localparam int HELD_WIDTH     = 8;
	localparam int MAX_POINTS_DEF = 128;

	// coordinate differences and their magnitude product
	localparam int DIFF_W = COORD_WIDTH + 1;
	localparam int PROD_W = 2 * DIFF_W;

	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_QUERY  = 1'b1;

	typedef enum logic [2:0] {
		ST_OK,
		ST_BEYOND,
		ST_UNDER_TWO,
		ST_ZERO_WIDTH,
		ST_FULL
	} status_t;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;

	typedef struct packed {
		logic   func;
		coord_t x_coord;
		coord_t y_coord;
	} item_t;

	typedef struct packed {
		status_t                status;
		coord_t                 line_y;
		logic                   is_above;
		logic [HELD_WIDTH-1:0]  points_held;
	} result_t;

endpackage

// File: src/pwl_ram.sv
// ----------------------------------------------------------------------------
// pwl_ram - generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pwl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// File: src/pwl_div.sv
// ----------------------------------------------------------------------------
// pwl_div - bit-serial restoring divider
// Unsigned quotient, one bit per cycle; done pulses once the last bit is in.
// ----------------------------------------------------------------------------
module pwl_div #(
	parameter int DVD_W = 34,
	parameter int DVS_W = 17
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0] acc_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W:0]   trial;
	logic [DVS_W:0]   diff;
	logic             take;

	assign trial = {rem_q, acc_q[DVD_W-1]};
	assign take  = (trial >= {1'b0, dvs_q});
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == CNT_W'(DVD_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= take ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
			acc_q <= {acc_q[DVD_W-2:0], take};
		end
	end

	assign done     = done_q;
	assign quotient = acc_q;

endmodule

// File: src/piecewise_linear_table_interp_unit.sv
// ----------------------------------------------------------------------------
// piecewise_linear_table_interp_unit - sorted breakpoint table with
// linear interpolation
// Inserts points in x order and answers line queries with an above flag.
// ----------------------------------------------------------------------------
// One item is in work at a time; item_stall stays high until its result is
// in the output register, which may still wait while the next item is taken.
// An insert shifts each held point with x greater than the new x up by one
// entry, one entry per cycle through the breakpoint RAM. A query walks the
// table with the RAM read port one entry a cycle up to the segment's right
// end; then, unless the segment has zero width, one multiply and a bit-serial
// divide follow. Status-only answers (table full, fewer than two points) go
// straight to the result.
module piecewise_linear_table_interp_unit #(
	parameter int MAX_POINTS = pwl_pkg::MAX_POINTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  pwl_pkg::item_t    item,
	output logic              result_valid,
	input  logic              result_stall,
	output pwl_pkg::result_t  result
);

	localparam int CW    = pwl_pkg::COORD_WIDTH;
	localparam int DW    = pwl_pkg::DIFF_W;
	localparam int PW    = pwl_pkg::PROD_W;
	localparam int SW    = PW + 2;
	localparam int IDX_W = $clog2(MAX_POINTS);
	localparam int CNT_W = $clog2(MAX_POINTS + 1);

	localparam logic signed [SW-1:0] SAT_HI = SW'((64'd1 << (CW - 1)) - 64'd1);
	localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS,
		S_SCAN,
		S_MUL,
		S_DSTART,
		S_DWAIT,
		S_SUM,
		S_FIN
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   idx_q;
	pwl_pkg::status_t   res_status_q;
	pwl_pkg::coord_t    res_line_q;

	logic               func_q;
	pwl_pkg::coord_t    x_q;
	pwl_pkg::coord_t    y_q;
	pwl_pkg::coord_t    prev_x_q;
	pwl_pkg::coord_t    prev_y_q;
	pwl_pkg::coord_t    y0_q;
	logic signed [DW-1:0] dw_q;
	logic signed [DW-1:0] dy_q;
	logic signed [DW-1:0] dx_q;
	logic               neg_q;
	logic [PW-1:0]      prod_q;

	logic               accept;
	logic               out_free;
	logic [2*CW-1:0]    rd_data;
	pwl_pkg::coord_t    rd_x;
	pwl_pkg::coord_t    rd_y;
	logic               shift_go;
	logic               found;
	logic               last;
	logic [CNT_W-1:0]   cnt_m1;
	logic [CNT_W-1:0]   idx_m2;
	logic [CNT_W-1:0]   idx_p1;
	logic               wr_en;
	logic [IDX_W-1:0]   wr_addr;
	logic [2*CW-1:0]    wr_data;
	logic [IDX_W-1:0]   rd_addr;

	logic [DW-1:0]      mag_dy;
	logic [DW-1:0]      mag_dx;
	logic [PW-1:0]      prod_c;
	logic               div_start;
	logic               div_done;
	logic [PW-1:0]      quot;
	logic signed [SW-1:0] q_ext;
	logic signed [SW-1:0] y0_ext;
	logic signed [SW-1:0] sum_c;
	pwl_pkg::coord_t    line_c;

	assign accept     = item_valid && !item_stall;
	assign item_stall = (state_q != S_IDLE);
	assign out_free   = !result_valid || !result_stall;

	assign rd_x = pwl_pkg::coord_t'(rd_data[2*CW-1:CW]);
	assign rd_y = pwl_pkg::coord_t'(rd_data[CW-1:0]);

	assign cnt_m1 = cnt_q - CNT_W'(1);
	assign idx_m2 = idx_q - CNT_W'(2);
	assign idx_p1 = idx_q + CNT_W'(1);

	assign shift_go = (idx_q != '0) && (x_q < rd_x);
	assign found    = (idx_q != '0) && (x_q <= rd_x);
	assign last     = (idx_q == cnt_m1);

	// breakpoint RAM access
	always_comb begin
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = idx_q[IDX_W-1:0];
		wr_data = {x_q, y_q};
		unique case (state_q)
			S_IDLE: begin
				if (item.func == pwl_pkg::FUNC_INSERT) begin
					rd_addr = cnt_m1[IDX_W-1:0];
				end
			end
			S_INS: begin
				rd_addr = idx_m2[IDX_W-1:0];
				wr_en   = 1'b1;
				wr_data = shift_go ? rd_data : {x_q, y_q};
			end
			S_SCAN: begin
				rd_addr = idx_p1[IDX_W-1:0];
			end
			default: begin
			end
		endcase
	end

	pwl_ram #(
		.WIDTH (2 * CW),
		.DEPTH (MAX_POINTS)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// |dy| * |dx|
	assign mag_dy = dy_q[DW-1] ? DW'(-dy_q) : DW'(dy_q);
	assign mag_dx = dx_q[DW-1] ? DW'(-dx_q) : DW'(dx_q);
	assign prod_c = PW'(mag_dy) * PW'(mag_dx);

	assign div_start = (state_q == S_DSTART);

	pwl_div #(
		.DVD_W (PW),
		.DVS_W (DW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_q),
		.divisor  (dw_q[DW-1:0]),
		.done     (div_done),
		.quotient (quot)
	);

	// y0 +/- quotient, saturated
	assign q_ext  = {2'b00, quot};
	assign y0_ext = {{(SW-CW){y0_q[CW-1]}}, y0_q};
	assign sum_c  = y0_ext + (neg_q ? -q_ext : q_ext);

	always_comb begin
		priority if (sum_c > SAT_HI) begin
			line_c = pwl_pkg::coord_t'(SAT_HI[CW-1:0]);
		end else if (sum_c < SAT_LO) begin
			line_c = pwl_pkg::coord_t'(SAT_LO[CW-1:0]);
		end else begin
			line_c = pwl_pkg::coord_t'(sum_c[CW-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			idx_q        <= '0;
			res_status_q <= pwl_pkg::ST_OK;
			res_line_q   <= '0;
			result_valid <= 1'b0;
			result       <= '0;
		end else begin
			if (result_valid && !result_stall && (state_q != S_FIN)) begin
				result_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_line_q <= '0;
						if (item.func == pwl_pkg::FUNC_INSERT) begin
							if (cnt_q == CNT_W'(MAX_POINTS)) begin
								res_status_q <= pwl_pkg::ST_FULL;
								state_q      <= S_FIN;
							end else begin
								idx_q   <= cnt_q;
								state_q <= S_INS;
							end
						end else if (cnt_q < CNT_W'(2)) begin
							res_status_q <= pwl_pkg::ST_UNDER_TWO;
							state_q      <= S_FIN;
						end else begin
							idx_q   <= '0;
							state_q <= S_SCAN;
						end
					end
				end
				S_INS: begin
					if (shift_go) begin
						idx_q <= idx_q - CNT_W'(1);
					end else begin
						cnt_q        <= cnt_q + CNT_W'(1);
						res_status_q <= pwl_pkg::ST_OK;
						state_q      <= S_FIN;
					end
				end
				S_SCAN: begin
					priority if (idx_q == '0) begin
						idx_q <= idx_p1;
					end else if (found) begin
						state_q <= S_MUL;
					end else if (last) begin
						res_status_q <= pwl_pkg::ST_BEYOND;
						state_q      <= S_FIN;
					end else begin
						idx_q <= idx_p1;
					end
				end
				S_MUL: begin
					if (dw_q[DW-1] || (dw_q == '0)) begin
						res_status_q <= pwl_pkg::ST_ZERO_WIDTH;
						res_line_q   <= y0_q;
						state_q      <= S_FIN;
					end else begin
						state_q <= S_DSTART;
					end
				end
				S_DSTART: begin
					state_q <= S_DWAIT;
				end
				S_DWAIT: begin
					if (div_done) begin
						state_q <= S_SUM;
					end
				end
				S_SUM: begin
					res_status_q <= pwl_pkg::ST_OK;
					res_line_q   <= line_c;
					state_q      <= S_FIN;
				end
				S_FIN: begin
					if (out_free) begin
						result_valid         <= 1'b1;
						result.status        <= res_status_q;
						result.line_y        <= res_line_q;
						result.is_above      <= (func_q == pwl_pkg::FUNC_QUERY) &&
						                        (y_q > res_line_q);
						result.points_held   <= pwl_pkg::HELD_WIDTH'(cnt_q);
						state_q              <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= item.func;
			x_q    <= item.x_coord;
			y_q    <= item.y_coord;
		end
		if (state_q == S_SCAN) begin
			prev_x_q <= rd_x;
			prev_y_q <= rd_y;
			y0_q     <= prev_y_q;
			dw_q     <= DW'(rd_x) - DW'(prev_x_q);
			dy_q     <= DW'(rd_y) - DW'(prev_y_q);
			dx_q     <= DW'(x_q) - DW'(prev_x_q);
		end
		if (state_q == S_MUL) begin
			prod_q <= prod_c;
			neg_q  <= dy_q[DW-1] ^ dx_q[DW-1];
		end
	end

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (result.status == pwl_pkg::ST_FULL)) |->
		(result.points_held == pwl_pkg::HELD_WIDTH'(MAX_POINTS)))
		else $error("table full reported below capacity");

	a_zero_line: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && ((result.status == pwl_pkg::ST_BEYOND) ||
		                  (result.status == pwl_pkg::ST_UNDER_TWO))) |->
		(result.line_y == '0))
		else $error("status-only query carries a line value");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DWAIT))
		else $error("divider finished outside its wait state");

	a_ins_grow: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_INS) && !shift_go) |=> (cnt_q == $past(cnt_q) + CNT_W'(1)))
		else $error("insert did not grow the point count");

endmodule
